[rtl/i2cm_pkg.sv]
package i2cm_pkg;

  // Action codes of an input item
  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4
  } act_t;

  // Command sequence in progress
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  localparam int unsigned DataBits = 8;
  localparam logic [15:0] PhaseTicksReset = 16'd10;

  // Register byte addresses
  localparam logic [2:0] REG_PHASE_TICKS = 3'd0;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       rejected;
    logic [7:0] read_byte;
    logic       read_valid;
  } out_item_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic rel;
  } lines_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        phase;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [15:0] tick_cnt;
    logic        ack;
    lines_t      lines;
  } seq_state_t;

  // Levels of the SCL-low phase of the current bit
  function automatic lines_t low_phase_lines(cmd_t cmd, logic [3:0] bit_cnt,
                                             logic [7:0] shreg, logic ack);
    lines_t l;
    l.scl = 1'b0;
    if (!bit_cnt[3]) begin
      if (cmd == CMD_WRITE) begin
        l.sda = shreg[3'd7 - bit_cnt[2:0]];
        l.rel = 1'b0;
      end else begin
        l.sda = 1'b1;
        l.rel = 1'b1;
      end
    end else begin
      l.rel = 1'b0;
      if (cmd == CMD_WRITE) begin
        l.sda = 1'b1;
      end else begin
        l.sda = ~ack;
      end
    end
    return l;
  endfunction

endpackage

[rtl/i2cm_step.sv]
module i2cm_step (
  input  i2cm_pkg::seq_state_t state,
  input  i2cm_pkg::in_item_t   item,
  input  logic [15:0]          phase_ticks,
  output i2cm_pkg::seq_state_t state_next,
  output i2cm_pkg::out_item_t  result
);

  logic        is_cmd;
  logic        busy;
  logic        rejected;
  logic        start_cmd;
  logic        tick;
  logic [15:0] limit;
  logic [16:0] tick_inc;
  logic        phase_end;
  logic        is_ss;
  logic        read_valid;

  // Classify the item against the current state
  assign is_cmd    = (item.action == i2cm_pkg::ACT_START) ||
                     (item.action == i2cm_pkg::ACT_STOP)  ||
                     (item.action == i2cm_pkg::ACT_WRITE) ||
                     (item.action == i2cm_pkg::ACT_READ);
  assign busy      = (state.cmd != i2cm_pkg::CMD_IDLE);
  assign rejected  = is_cmd && busy;
  assign start_cmd = is_cmd && !busy;
  assign tick      = (item.action == i2cm_pkg::ACT_TICK) && busy;
  assign limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign tick_inc  = {1'b0, state.tick_cnt} + 17'd1;
  assign phase_end = tick && (tick_inc >= {1'b0, limit});
  assign is_ss     = (state.cmd == i2cm_pkg::CMD_START) || (state.cmd == i2cm_pkg::CMD_STOP);

  // Advance command, phase, counters, shift register and line levels
  always_comb begin
    state_next.cmd      = state.cmd;
    state_next.phase    = state.phase;
    state_next.bit_cnt  = state.bit_cnt;
    state_next.shreg    = state.shreg;
    state_next.tick_cnt = state.tick_cnt;
    state_next.ack      = state.ack;
    state_next.lines    = state.lines;
    read_valid          = 1'b0;
    if (start_cmd) begin
      state_next.cmd      = i2cm_pkg::cmd_t'(item.action);
      state_next.phase    = 1'b0;
      state_next.bit_cnt  = 4'd0;
      state_next.tick_cnt = 16'd0;
      if (item.action == i2cm_pkg::ACT_WRITE) begin
        state_next.shreg = item.write_byte;
        state_next.ack   = item.send_ack;
      end else if (item.action == i2cm_pkg::ACT_READ) begin
        state_next.shreg = 8'd0;
        state_next.ack   = item.send_ack;
      end
    end else if (tick) begin
      if (phase_end) begin
        state_next.tick_cnt = 16'd0;
        if (is_ss) begin
          if (!state.phase) begin
            state_next.phase = 1'b1;
          end else begin
            state_next.cmd   = i2cm_pkg::CMD_IDLE;
            state_next.phase = 1'b0;
          end
        end else if (!state.phase) begin
          state_next.phase = 1'b1;
        end else begin
          // Sample SDA at the end of SCL high on read data bits
          if (state.cmd == i2cm_pkg::CMD_READ && !state.bit_cnt[3]) begin
            state_next.shreg = {state.shreg[6:0], item.sda_in};
          end
          if (state.bit_cnt[3]) begin
            state_next.cmd     = i2cm_pkg::CMD_IDLE;
            state_next.phase   = 1'b0;
            state_next.bit_cnt = 4'd0;
          end else begin
            state_next.bit_cnt = state.bit_cnt + 4'd1;
            state_next.phase   = 1'b0;
          end
        end
      end else begin
        state_next.tick_cnt = tick_inc[15:0];
      end
    end

    // Drive line levels for the new phase
    if (start_cmd) begin
      case (item.action)
        i2cm_pkg::ACT_START: state_next.lines = '{scl: 1'b1, sda: 1'b1, rel: 1'b0};
        i2cm_pkg::ACT_STOP:  state_next.lines = '{scl: 1'b1, sda: 1'b0, rel: 1'b0};
        default: begin
          state_next.lines = i2cm_pkg::low_phase_lines(i2cm_pkg::cmd_t'(item.action),
                                                       4'd0, state_next.shreg,
                                                       item.send_ack);
        end
      endcase
    end else if (phase_end) begin
      if (is_ss) begin
        if (!state.phase) begin
          state_next.lines.scl = 1'b1;
          state_next.lines.sda = (state.cmd == i2cm_pkg::CMD_STOP);
          state_next.lines.rel = 1'b0;
        end
      end else if (!state.phase) begin
        state_next.lines.scl = 1'b1;
      end else if (state.bit_cnt[3]) begin
        state_next.lines.scl = 1'b0;
        read_valid           = (state.cmd == i2cm_pkg::CMD_READ);
      end else begin
        state_next.lines = i2cm_pkg::low_phase_lines(state.cmd, state_next.bit_cnt,
                                                     state_next.shreg, state.ack);
      end
    end
  end

  // Drive the result
  always_comb begin
    result.scl_level    = state_next.lines.scl;
    result.sda_level    = state_next.lines.sda;
    result.sda_released = state_next.lines.rel;
    result.busy_res     = (state_next.cmd != i2cm_pkg::CMD_IDLE);
    result.rejected     = rejected;
    result.read_byte    = read_valid ? state_next.shreg : 8'd0;
    result.read_valid   = read_valid;
  end

endmodule

[rtl/bit_banged_i2c_master.sv]
// I2C master line sequencer, timed by tick items.
// Input channel (in_valid / in_stall / in_item): each item is a tick or a
// command (start, stop, write byte, read byte). Output channel (out_valid /
// out_stall / out_item): exactly one result per input item, in order, giving
// the SCL/SDA levels, SDA direction, busy, rejected and any finished read byte.
// The whole step is decided in the cycle the item is accepted and the result
// is registered, in the result or skid register, at that edge.
// Throughput: one item per cycle while in_stall is low, set by the single
// registered pass through the sequencer step logic.
// A two-entry output stage (result register plus skid register) lets an item
// be taken while a result waits; in_stall rises only when both entries are
// full, i.e. after an item is accepted while the receiver holds out_stall with
// a result pending.
// Reset (rst, synchronous): sequencer idle, lines SCL high / SDA high driven,
// phase_ticks back to 10, output stage empty. phase_ticks is written via APB at
// paddr 0-3, read at 0; the user must write it only while idle (unenforced).
module bit_banged_i2c_master (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0]          phase_ticks;
  i2cm_pkg::seq_state_t state;
  i2cm_pkg::seq_state_t state_next;
  i2cm_pkg::out_item_t  step_result;
  i2cm_pkg::out_item_t  skid_item;
  logic                 skid_valid;
  logic                 acc;
  logic                 out_taken;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == i2cm_pkg::REG_PHASE_TICKS) ? {16'd0, phase_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cm_pkg::PhaseTicksReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      phase_ticks <= pwdata[15:0];
    end
  end

  // Sequencer step
  i2cm_step u_step (
    .state       (state),
    .item        (in_item),
    .phase_ticks (phase_ticks),
    .state_next  (state_next),
    .result      (step_result)
  );

  assign in_stall  = skid_valid;
  assign acc       = in_valid && !skid_valid;
  assign out_taken = out_valid && !out_stall;

  // Hold sequencer state, advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      state.cmd      <= i2cm_pkg::CMD_IDLE;
      state.phase    <= 1'b0;
      state.bit_cnt  <= 4'd0;
      state.shreg    <= 8'd0;
      state.tick_cnt <= 16'd0;
      state.ack      <= 1'b0;
      state.lines    <= '{scl: 1'b1, sda: 1'b1, rel: 1'b0};
    end else if (acc) begin
      state <= state_next;
    end
  end

  // Output stage control: result register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_taken) begin
        skid_valid <= 1'b0;
      end
    end else if (acc) begin
      if (out_valid && !out_taken) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_taken) begin
      out_valid <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_taken) begin
        out_item <= skid_item;
      end
    end else if (acc) begin
      if (out_valid && !out_taken) begin
        skid_item <= step_result;
      end else begin
        out_item <= step_result;
      end
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
module tb;

  localparam logic [2:0] ActUndefLo = 3'd5;
  localparam logic [2:0] ActUndefHi = 3'd7;
  localparam logic [2:0] RegUnused = 3'd4;
  localparam int MaxCycles = 2_000_000;
  localparam int IdlePct = 11;
  localparam int RandomPhases = 7;
  localparam int ItemsPerPhase = 60;
  localparam int LongPhaseTicks = 40;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  i2cm_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall = 1'b0;
  i2cm_pkg::out_item_t out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Shadow copy of the sequencer and its register
  i2cm_pkg::cmd_t      seq_cmd;
  logic                seq_high;
  logic [3:0]          seq_bit;
  logic [7:0]          seq_shift;
  logic [15:0]         seq_ticks;
  logic                seq_ack;
  logic                line_scl;
  logic                line_sda;
  logic                line_rel;
  logic [15:0]         phase_ticks;

  i2cm_pkg::out_item_t line_forecast[$];
  i2cm_pkg::out_item_t oldest_line;
  int                  items_sent;
  int                  results_seen;
  int                  mismatch_count;
  int                  cycle_count;
  int                  in_idle_pct;
  int                  out_idle_pct;

  bit_banged_i2c_master dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("%0t: timeout with %0d results outstanding", $time, line_forecast.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void clear_model();
    seq_cmd = i2cm_pkg::CMD_IDLE;
    seq_high = 1'b0;
    seq_bit = '0;
    seq_shift = '0;
    seq_ticks = '0;
    seq_ack = 1'b0;
    line_scl = 1'b1;
    line_sda = 1'b1;
    line_rel = 1'b0;
    phase_ticks = i2cm_pkg::PhaseTicksReset;
  endfunction

  // A released SDA always reads back as a driven one
  function automatic void drive_lines(logic scl, logic sda, logic rel);
    line_scl = scl;
    line_sda = rel ? 1'b1 : sda;
    line_rel = rel;
  endfunction

  // Set the SCL-low levels of the current bit or of the ACK clock
  function automatic void load_low_phase();
    if (seq_bit < i2cm_pkg::DataBits) begin
      if (seq_cmd == i2cm_pkg::CMD_WRITE) begin
        drive_lines(1'b0, seq_shift[7 - seq_bit], 1'b0);
      end else begin
        drive_lines(1'b0, 1'b1, 1'b1);
      end
    end else if (seq_cmd == i2cm_pkg::CMD_WRITE) begin
      drive_lines(1'b0, 1'b1, 1'b0);
    end else begin
      drive_lines(1'b0, ~seq_ack, 1'b0);
    end
  endfunction

  // Finish the current phase; return 1 when a read byte is complete
  function automatic logic close_phase(logic sda);
    logic was_read;
    if (seq_cmd == i2cm_pkg::CMD_START || seq_cmd == i2cm_pkg::CMD_STOP) begin
      if (!seq_high) begin
        seq_high = 1'b1;
        drive_lines(1'b1, seq_cmd == i2cm_pkg::CMD_STOP, 1'b0);
      end else begin
        seq_cmd = i2cm_pkg::CMD_IDLE;
        seq_high = 1'b0;
      end
      return 1'b0;
    end
    if (!seq_high) begin
      seq_high = 1'b1;
      line_scl = 1'b1;
      return 1'b0;
    end
    if (seq_cmd == i2cm_pkg::CMD_READ && seq_bit < i2cm_pkg::DataBits) begin
      seq_shift = {seq_shift[6:0], sda};
    end
    if (seq_bit >= i2cm_pkg::DataBits) begin
      was_read = (seq_cmd == i2cm_pkg::CMD_READ);
      line_scl = 1'b0;
      seq_cmd = i2cm_pkg::CMD_IDLE;
      seq_high = 1'b0;
      seq_bit = '0;
      return was_read;
    end
    seq_bit = seq_bit + 4'd1;
    seq_high = 1'b0;
    load_low_phase();
    return 1'b0;
  endfunction

  // Advance the shadow sequencer by one item and return the line levels after it
  function automatic i2cm_pkg::out_item_t predict_lines(i2cm_pkg::in_item_t it);
    i2cm_pkg::out_item_t r;
    logic                busy;
    logic                done;
    logic                dropped;
    logic [16:0]         nxt;
    logic [16:0]         lim;
    busy = (seq_cmd != i2cm_pkg::CMD_IDLE);
    done = 1'b0;
    dropped = 1'b0;
    if (it.action >= i2cm_pkg::ACT_START && it.action <= i2cm_pkg::ACT_READ) begin
      if (busy) begin
        dropped = 1'b1;
      end else begin
        seq_high = 1'b0;
        seq_bit = '0;
        seq_ticks = '0;
        case (it.action)
          i2cm_pkg::ACT_START: begin
            seq_cmd = i2cm_pkg::CMD_START;
            drive_lines(1'b1, 1'b1, 1'b0);
          end
          i2cm_pkg::ACT_STOP: begin
            seq_cmd = i2cm_pkg::CMD_STOP;
            drive_lines(1'b1, 1'b0, 1'b0);
          end
          i2cm_pkg::ACT_WRITE: begin
            seq_cmd = i2cm_pkg::CMD_WRITE;
            seq_shift = it.write_byte;
            seq_ack = it.send_ack;
            load_low_phase();
          end
          default: begin
            seq_cmd = i2cm_pkg::CMD_READ;
            seq_shift = '0;
            seq_ack = it.send_ack;
            load_low_phase();
          end
        endcase
      end
    end else if (it.action == i2cm_pkg::ACT_TICK && busy) begin
      lim = (phase_ticks == '0) ? 17'd1 : {1'b0, phase_ticks};
      nxt = {1'b0, seq_ticks} + 17'd1;
      if (nxt >= lim) begin
        seq_ticks = '0;
        done = close_phase(it.sda_in);
      end else begin
        seq_ticks = nxt[15:0];
      end
    end
    r.scl_level = line_scl;
    r.sda_level = line_sda;
    r.sda_released = line_rel;
    r.busy_res = (seq_cmd != i2cm_pkg::CMD_IDLE);
    r.rejected = dropped;
    r.read_byte = done ? seq_shift : 8'h00;
    r.read_valid = done;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Predict on every accepted item, compare every accepted result, stall at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
    if (!rst) begin
      if (in_valid && !in_stall) line_forecast.push_back(predict_lines(in_item));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (line_forecast.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, got %h",
                   $time, out_item);
          mismatch_count++;
        end else begin
          oldest_line = line_forecast.pop_front();
          check_field("scl_level", 8'(oldest_line.scl_level), 8'(out_item.scl_level));
          check_field("sda_level", 8'(oldest_line.sda_level), 8'(out_item.sda_level));
          check_field("sda_released", 8'(oldest_line.sda_released),
                      8'(out_item.sda_released));
          check_field("busy_res", 8'(oldest_line.busy_res), 8'(out_item.busy_res));
          check_field("rejected", 8'(oldest_line.rejected), 8'(out_item.rejected));
          check_field("read_byte", oldest_line.read_byte, out_item.read_byte);
          check_field("read_valid", 8'(oldest_line.read_valid), 8'(out_item.read_valid));
        end
      end
    end
  end

  function automatic i2cm_pkg::in_item_t make_item(logic [2:0] act, logic [7:0] data,
                                                   logic ack, logic sda);
    i2cm_pkg::in_item_t it;
    it.action = act;
    it.write_byte = data;
    it.send_ack = ack;
    it.sda_in = sda;
    return it;
  endfunction

  // Offer one item, idling at random first, and hold it until taken
  task automatic send_item(i2cm_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Offer one tick item with random filler fields
  task automatic send_tick();
    send_item(make_item(i2cm_pkg::ACT_TICK, 8'($urandom()), 1'($urandom()),
                        1'($urandom())));
  endtask

  // Drop valid and wait for every result to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != items_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == i2cm_pkg::REG_PHASE_TICKS) phase_ticks = data[15:0];
  endtask

  task automatic read_reg(logic [2:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_phase_ticks();
    logic [31:0] rd;
    read_reg(i2cm_pkg::REG_PHASE_TICKS, rd);
    if (rd[15:0] !== phase_ticks) begin
      $display("%0t: phase_ticks readback mismatch: expected %0h, got %0h",
               $time, phase_ticks, rd[15:0]);
      mismatch_count++;
    end
  endtask

  // Upper data bits are junk; only the low half lands in the register
  task automatic set_phase_ticks(logic [15:0] value);
    write_reg(i2cm_pkg::REG_PHASE_TICKS, {16'($urandom()), value});
    check_phase_ticks();
  endtask

  // Items that a busy sequencer must drop or ignore
  task automatic send_busy_noise();
    if ($urandom_range(1)) begin
      send_item(make_item(3'($urandom_range(i2cm_pkg::ACT_READ, i2cm_pkg::ACT_START)),
                          8'($urandom()), 1'($urandom()), 1'($urandom())));
    end else begin
      send_item(make_item(3'($urandom_range(ActUndefHi, ActUndefLo)), 8'($urandom()),
                          1'($urandom()), 1'($urandom())));
    end
  endtask

  // Items that an idle sequencer must ignore
  task automatic send_idle_noise();
    if ($urandom_range(1)) begin
      send_tick();
    end else begin
      send_item(make_item(3'($urandom_range(ActUndefHi, ActUndefLo)), 8'($urandom()),
                          1'($urandom()), 1'($urandom())));
    end
  endtask

  // Issue one command and tick it through to idle, with busy noise mixed in
  task automatic run_command(i2cm_pkg::act_t cmd, logic [7:0] data, logic ack,
                             int sda_bias, int noise_pct);
    int ticks_left;
    int per_phase;
    per_phase = (phase_ticks == '0) ? 1 : int'(phase_ticks);
    if (cmd == i2cm_pkg::ACT_START || cmd == i2cm_pkg::ACT_STOP) begin
      ticks_left = 2 * per_phase;
    end else begin
      ticks_left = 2 * (i2cm_pkg::DataBits + 1) * per_phase;
    end
    send_item(make_item(cmd, data, ack, 1'($urandom())));
    while (ticks_left > 0) begin
      if ($urandom_range(99) < noise_pct) begin
        send_busy_noise();
      end else begin
        send_item(make_item(i2cm_pkg::ACT_TICK, 8'($urandom()), 1'($urandom()),
                            $urandom_range(99) < sda_bias));
        ticks_left--;
      end
    end
  endtask

  task automatic test_register_reset();
    check_phase_ticks();
    write_reg(RegUnused, $urandom());
    check_phase_ticks();
  endtask

  task automatic test_idle_items();
    send_item(make_item(i2cm_pkg::ACT_TICK, 8'hFF, 1'b1, 1'b1));
    for (int a = ActUndefLo; a <= ActUndefHi; a++) begin
      send_item(make_item(3'(a), 8'($urandom()), 1'($urandom()), 1'($urandom())));
    end
    drain_results();
  endtask

  task automatic test_commands();
    set_phase_ticks(16'd1);
    run_command(i2cm_pkg::ACT_START, 8'h00, 1'b0, 50, 0);
    run_command(i2cm_pkg::ACT_WRITE, 8'hFF, 1'b1, 50, 0);
    run_command(i2cm_pkg::ACT_WRITE, 8'h00, 1'b0, 50, 0);
    run_command(i2cm_pkg::ACT_READ, 8'h5A, 1'b1, 100, 0);
    run_command(i2cm_pkg::ACT_READ, 8'hA5, 1'b0, 0, 0);
    run_command(i2cm_pkg::ACT_STOP, 8'h00, 1'b0, 50, 0);
    drain_results();
    // zero behaves as one; commands while busy are dropped
    set_phase_ticks(16'd0);
    run_command(i2cm_pkg::ACT_START, 8'h00, 1'b1, 50, 30);
    run_command(i2cm_pkg::ACT_WRITE, 8'hA5, 1'b0, 50, 30);
    run_command(i2cm_pkg::ACT_READ, 8'h00, 1'b1, 50, 30);
    run_command(i2cm_pkg::ACT_STOP, 8'h00, 1'b0, 50, 30);
    drain_results();
  endtask

  // Count well into a full-width phase, then close it under a short limit
  task automatic test_long_phase();
    set_phase_ticks(16'hFFFF);
    send_item(make_item(i2cm_pkg::ACT_START, 8'h00, 1'b0, 1'b1));
    repeat (LongPhaseTicks) send_tick();
    drain_results();
    set_phase_ticks(16'd3);
    repeat (4) send_tick();
    run_command(i2cm_pkg::ACT_STOP, 8'h00, 1'b0, 50, 5);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int start_count;
    logic [15:0] per;
    for (int p = 0; p < RandomPhases; p++) begin
      // one phase runs flat out on both sides
      in_idle_pct = (p == RandomPhases / 2) ? 0 : IdlePct;
      out_idle_pct = in_idle_pct;
      per = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(4, 1));
      set_phase_ticks(per);
      start_count = items_sent;
      while (items_sent - start_count < ItemsPerPhase) begin
        if ($urandom_range(99) < 10) begin
          send_idle_noise();
        end else begin
          run_command(i2cm_pkg::act_t'($urandom_range(i2cm_pkg::ACT_READ,
                                                      i2cm_pkg::ACT_START)),
                      8'($urandom()), 1'($urandom()), 50, 5);
        end
      end
      drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    results_seen = 0;
    mismatch_count = 0;
    cycle_count = 0;
    in_idle_pct = IdlePct;
    out_idle_pct = IdlePct;
    clear_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_idle_items();
    test_commands();
    test_long_phase();
    test_random_traffic();
    drain_results();

    if (line_forecast.size() != 0) begin
      $display("%0t: results missing: expected %0d more, got 0", $time,
               line_forecast.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/i2cm_pkg.sv
rtl/i2cm_step.sv
rtl/bit_banged_i2c_master.sv
test/tb.sv
